@@ src/assert_macros.svh @@
// Assertion macros used by the checker file of this block.
// Needs nothing else; include it by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop on every rising edge of clk, idle while rst is high.
`define ASSERT_CLKED(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Check that expr is never true on a rising edge of clk.
`define ASSERT_NEVER(label, clk, rst, expr) \
   `ASSERT_CLKED(label, clk, rst, !(expr))

`endif

@@ src/mscd_pkg.sv @@
// Package for the countdown timer table: sizes, command, status and state codes.
// No dependencies; used by the top level and the checker.
package mscd_pkg;

   localparam int NUM_SLOTS  = 16;
   localparam int COUNT_BITS = 16;
   localparam int MAX_OUT    = 16;
   localparam int SLOT_BITS  = $clog2(NUM_SLOTS);
   localparam int FIRE_BITS  = $clog2(MAX_OUT + 1);

   typedef enum logic [1:0] {
      CMD_ADD    = 2'd0,
      CMD_CANCEL = 2'd1,
      CMD_START  = 2'd2,
      CMD_TICK   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_NOJOB = 2'd2,
      STAT_FIRED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_PRIME,
      S_WALK,
      S_FLUSH
   } state_type;

endpackage

@@ src/mscd_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mscd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/multi_slot_countdown_timer.sv @@
// Countdown timer table: occupancy flags, count RAM and slot walk sequencer.
// Depends on mscd_pkg and mscd_ram.
//
// Usage:
//   req channel carries one command per item: add (claims the lowest free slot and
//   loads its count), cancel, start, or a one-second tick.
//   rsp channel returns results: add, cancel and start give one result each, a tick
//   gives one fired result per slot that expires, in slot order, tlast on the final.
//   Add, cancel and start load their result into the output register on the next
//   cycle. A tick walks the count RAM one slot per cycle while the receiver does not
//   hold the walk, read of the next slot overlapped with write-back of the current
//   one; the single RAM read port limits the walk to one slot read at a time.
//   A tick before start, or one that fires nothing, gives no result.
//   Reset clears the occupancy and fired flags and the running flag; the count RAM
//   needs no clearing since a free slot's count is never used.
//   When the receiver stalls, the result holds in the output register; the walk
//   pauses only when a further firing needs the register, and no new item is
//   taken until the walk ends.
module multi_slot_countdown_timer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // seconds[15:0], slot_id[19:16], zero [23:20]
   input  logic [1:0]  req_tuser,   // cmd[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // slot[3:0], zero [7:4]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   import mscd_pkg::*;

   state_type             state_ff, state_in;
   logic [SLOT_BITS-1:0]  idx_ff, idx_in;
   logic [FIRE_BITS-1:0]  nfire_ff, nfire_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SLOT_BITS-1:0]  pend_slot_ff, pend_slot_in;
   logic [NUM_SLOTS-1:0]  used_ff, used_in;
   logic [NUM_SLOTS-1:0]  fired_ff, fired_in;
   logic                  running_ff, running_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [3:0]            rsp_slot_ff, rsp_slot_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  wr_en, rd_en;
   logic [SLOT_BITS-1:0]  wr_addr, rd_addr;
   logic [COUNT_BITS-1:0] wr_data, rd_data;

   logic                  out_free, req_fire;
   cmd_type               cmd;
   logic [15:0]           seconds;
   logic [3:0]            slot_id;
   logic                  free_found;
   logic [SLOT_BITS-1:0]  free_idx;
   logic [SLOT_BITS-1:0]  cancel_idx;
   logic                  cancel_ok;
   logic                  live, cnt_zero, cnt_one, fire, stall, last_idx;
   logic [COUNT_BITS-1:0] cnt_dec;

   mscd_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_SLOTS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;
   assign req_fire   = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign seconds    = req_tdata[15:0];
   assign slot_id    = req_tdata[19:16];

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_BITS'(i);
         end
      end
   end

   assign cancel_idx = SLOT_BITS'(slot_id);
   assign cancel_ok  = (int'(slot_id) < NUM_SLOTS) && used_ff[cancel_idx];

   assign live     = used_ff[idx_ff] && !fired_ff[idx_ff];
   assign cnt_dec  = rd_data - 1'b1;
   assign cnt_zero = (rd_data == '0);
   assign cnt_one  = (rd_data == COUNT_BITS'(1));
   assign fire     = live && (cnt_zero || cnt_one) && (int'(nfire_ff) < MAX_OUT);
   assign stall    = fire && pend_valid_ff && !out_free;
   assign last_idx = (idx_ff == SLOT_BITS'(NUM_SLOTS - 1));

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      nfire_in      = nfire_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      used_in       = used_ff;
      fired_in      = fired_ff;
      running_in    = running_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = cnt_dec;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (cmd)
                  CMD_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     if (free_found) begin
                        used_in[free_idx]  = 1'b1;
                        fired_in[free_idx] = 1'b0;
                        wr_en              = 1'b1;
                        wr_addr            = free_idx;
                        wr_data            = COUNT_BITS'(seconds);
                        rsp_status_in      = STAT_OK;
                        rsp_slot_in        = 4'(free_idx);
                     end else begin
                        rsp_status_in = STAT_FULL;
                        rsp_slot_in   = 4'd0;
                     end
                  end
                  CMD_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     rsp_last_in  = 1'b1;
                     rsp_slot_in  = slot_id;
                     if (cancel_ok) begin
                        used_in[cancel_idx]  = 1'b0;
                        fired_in[cancel_idx] = 1'b0;
                        rsp_status_in        = STAT_OK;
                     end else begin
                        rsp_status_in = STAT_NOJOB;
                     end
                  end
                  CMD_START: begin
                     running_in    = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_last_in   = 1'b1;
                     rsp_status_in = STAT_OK;
                     rsp_slot_in   = 4'd0;
                  end
                  CMD_TICK: begin
                     if (running_ff) begin
                        state_in      = S_PRIME;
                        idx_in        = '0;
                        nfire_in      = '0;
                        pend_valid_in = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_PRIME: begin
            rd_en    = 1'b1;
            state_in = S_WALK;
         end
         S_WALK: begin
            if (!stall) begin
               if (live && !cnt_zero) begin
                  wr_en = 1'b1;
               end
               if (fire) begin
                  fired_in[idx_ff] = 1'b1;
                  nfire_in         = nfire_ff + 1'b1;
                  pend_valid_in    = 1'b1;
                  pend_slot_in     = idx_ff;
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_FIRED;
                     rsp_slot_in   = 4'(pend_slot_ff);
                     rsp_last_in   = 1'b0;
                  end
               end
               if (last_idx) begin
                  state_in = S_FLUSH;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + 1'b1;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_FIRED;
               rsp_slot_in   = 4'(pend_slot_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         nfire_ff      <= '0;
         pend_valid_ff <= 1'b0;
         used_ff       <= '0;
         fired_ff      <= '0;
         running_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         nfire_ff      <= nfire_in;
         pend_valid_ff <= pend_valid_in;
         used_ff       <= used_in;
         fired_ff      <= fired_in;
         running_ff    <= running_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff  <= pend_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ src/mscd_checker.sv @@
// Port-level checker for the countdown timer table, bound to the top level.
// Depends on mscd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mscd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,   // seconds[15:0], slot_id[19:16], zero [23:20]
   input logic [1:0]  req_tuser,   // cmd[1:0]
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,   // slot[3:0], zero [7:4]
   input logic [1:0]  rsp_tuser,   // status[1:0]
   input logic        rsp_tlast
);

   import mscd_pkg::*;

   logic [10:0] rsp_word;
   logic        mid_tick;

   assign rsp_word = {rsp_tlast, rsp_tuser, rsp_tdata};
   assign mid_tick = rsp_tvalid && (rsp_tuser == STAT_FIRED) && !rsp_tlast;

   `ASSERT_CLKED(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_word))

   `ASSERT_CLKED(a_single_last, clock, reset, rsp_tvalid && (rsp_tuser != STAT_FIRED) |-> rsp_tlast)

   `ASSERT_NEVER(a_no_take_mid_tick, clock, reset, mid_tick && req_tready)

   `ASSERT_CLKED(a_quiet_after_reset, clock, reset, $past(reset) |-> !rsp_tvalid)

   `ASSERT_NEVER(a_pad_zero, clock, reset, rsp_tvalid && (rsp_tdata[7:4] != 4'd0))

endmodule

bind multi_slot_countdown_timer mscd_checker u_mscd_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for multi_slot_countdown_timer: directed and random command
// streams with random idling on both channels, checked against an in-bench timer table.
// Depends on mscd_pkg and the RTL of the block.
module testbench;
   import mscd_pkg::*;

   typedef struct packed {
      status_type  status;
      logic [3:0]  slot;
      logic        last;
   } timer_result_type;

   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int WALK_CYCLES = 2 * NUM_SLOTS + 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // seconds[15:0], slot_id[19:16], zero [23:20]
   logic [1:0]  req_tuser = '0;   // cmd[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // slot[3:0], zero [7:4]
   logic [1:0]  rsp_tuser;        // status[1:0]
   logic        rsp_tlast;

   logic                  slot_busy      [NUM_SLOTS] = '{default: 1'b0};
   logic [COUNT_BITS-1:0] slot_remaining [NUM_SLOTS] = '{default: '0};
   logic                  slot_expired   [NUM_SLOTS] = '{default: 1'b0};
   logic                  counting = 1'b0;

   timer_result_type expected_results [$];
   timer_result_type head;

   logic idle_on = 1'b1;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   hold_left = 0;
   int   stall_cycles = 0;
   int   errors = 0;
   int   items_sent = 0;
   int   results_seen = 0;
   int   fired_seen = 0;
   int   full_seen = 0;
   int   nojob_seen = 0;

   multi_slot_countdown_timer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic void timer_table_step(cmd_type cmd, logic [15:0] secs,
                                            logic [3:0] id);
      timer_result_type r;
      int               free_slot;
      int               fires;
      logic             fire;
      free_slot = -1;
      fires = 0;
      case (cmd)
         CMD_ADD: begin
            for (int i = 0; i < NUM_SLOTS; i++)
               if (free_slot < 0 && !slot_busy[i]) free_slot = i;
            if (free_slot < 0) begin
               r = '{STAT_FULL, 4'd0, 1'b1};
            end else begin
               slot_busy[free_slot] = 1'b1;
               slot_remaining[free_slot] = secs[COUNT_BITS-1:0];
               slot_expired[free_slot] = 1'b0;
               r = '{STAT_OK, 4'(free_slot), 1'b1};
            end
            expected_results.push_back(r);
         end
         CMD_CANCEL: begin
            if (id < NUM_SLOTS && slot_busy[id]) begin
               slot_busy[id] = 1'b0;
               slot_remaining[id] = '0;
               slot_expired[id] = 1'b0;
               r = '{STAT_OK, id, 1'b1};
            end else begin
               r = '{STAT_NOJOB, id, 1'b1};
            end
            expected_results.push_back(r);
         end
         CMD_START: begin
            counting = 1'b1;
            r = '{STAT_OK, 4'd0, 1'b1};
            expected_results.push_back(r);
         end
         CMD_TICK: begin
            if (counting) begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (slot_busy[i] && !slot_expired[i]) begin
                     if (slot_remaining[i] == 0) begin
                        fire = 1'b1;
                     end else begin
                        slot_remaining[i] = slot_remaining[i] - 1'b1;
                        fire = (slot_remaining[i] == 0);
                     end
                     if (fire && fires < MAX_OUT) begin
                        slot_expired[i] = 1'b1;
                        r = '{STAT_FIRED, 4'(i), 1'b0};
                        expected_results.push_back(r);
                        fires++;
                     end
                  end
               end
               if (fires > 0) expected_results[expected_results.size() - 1].last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_item(cmd_type cmd, logic [15:0] secs, logic [3:0] id);
      while (idle_on && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, id, secs};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
      timer_table_step(cmd, secs, id);
      items_sent++;
   endtask

   task automatic send_random_item();
      int          pick;
      int          busy_list [$];
      logic [15:0] secs;
      logic [3:0]  id;
      pick = $urandom_range(99);
      if (pick < 70)      secs = 16'($urandom_range(0, 6));
      else if (pick < 90) secs = 16'($urandom_range(7, 40));
      else                secs = 16'($urandom);
      for (int i = 0; i < NUM_SLOTS; i++)
         if (slot_busy[i]) busy_list.push_back(i);
      if (busy_list.size() > 0 && $urandom_range(9) < 8)
         id = 4'(busy_list[$urandom_range(busy_list.size() - 1)]);
      else
         id = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 30)      send_item(CMD_ADD, secs, id);
      else if (pick < 55) send_item(CMD_CANCEL, secs, id);
      else if (pick < 60) send_item(CMD_START, secs, id);
      else                send_item(CMD_TICK, secs, id);
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_results.size() != 0);
   endtask

   task automatic test_before_start();
      send_item(CMD_TICK, 16'd3, 4'd0);
      send_item(CMD_CANCEL, 16'd0, 4'd15);
      send_item(CMD_ADD, 16'd0, 4'd0);
      send_item(CMD_ADD, 16'd5, 4'd0);
      send_item(CMD_CANCEL, 16'hFFFF, 4'd1);
      send_item(CMD_TICK, 16'd0, 4'd0);
      wait_for_results();
   endtask

   task automatic test_start_and_fire();
      send_item(CMD_START, 16'd0, 4'd0);
      send_item(CMD_START, 16'hFFFF, 4'd15);
      send_item(CMD_TICK, 16'd0, 4'd0);
      send_item(CMD_TICK, 16'd0, 4'd0);
      wait_for_results();
   endtask

   task automatic test_full_table();
      for (int i = 1; i < NUM_SLOTS; i++)
         send_item(CMD_ADD, (i == 1) ? 16'hFFFF : (i % 3 == 0) ? 16'd2 : 16'd1, 4'd0);
      send_item(CMD_ADD, 16'd7, 4'd0);
      send_item(CMD_TICK, 16'd0, 4'd0);
      send_item(CMD_TICK, 16'd0, 4'd0);
      wait_for_results();
   endtask

   task automatic test_output_backpressure();
      holds_asked <= holds_asked + 1;
      repeat (40) send_random_item();
      wait_for_results();
   endtask

   task automatic test_sender_pauses();
      repeat (4) begin
         repeat (10) send_random_item();
         wait_for_results();
      end
   endtask

   task automatic test_streaming();
      idle_on <= 1'b0;
      repeat (80) send_random_item();
      wait_for_results();
      idle_on <= 1'b1;
   endtask

   task automatic test_random_traffic();
      repeat (260) send_random_item();
      wait_for_results();
   endtask

   always @(posedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done <= holds_asked;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !idle_on || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result: status %0d slot %0d last %0d",
                     $time, rsp_tuser, rsp_tdata[3:0], rsp_tlast);
            errors++;
         end else begin
            head = expected_results.pop_front();
            if (rsp_tuser !== head.status) begin
               $display("%0t: status mismatch: expected %0d, actual %0d",
                        $time, head.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[3:0] !== head.slot) begin
               $display("%0t: slot mismatch: expected %0d, actual %0d",
                        $time, head.slot, rsp_tdata[3:0]);
               errors++;
            end
            if (rsp_tlast !== head.last) begin
               $display("%0t: last mismatch: expected %0d, actual %0d",
                        $time, head.last, rsp_tlast);
               errors++;
            end
            if (head.status == STAT_FIRED) fired_seen++;
            if (head.status == STAT_FULL)  full_seen++;
            if (head.status == STAT_NOJOB) nojob_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles, %0d results outstanding",
                  $time, STALL_LIMIT, expected_results.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_before_start();
      test_start_and_fire();
      test_full_table();
      test_output_backpressure();
      test_sender_pauses();
      test_streaming();
      test_random_traffic();
      repeat (WALK_CYCLES) @(posedge clock);
      $display("Sent %0d commands, checked %0d results: %0d firings, %0d table-full, %0d no-job",
               items_sent, results_seen, fired_seen, full_seen, nojob_seen);
      $display("Covered ticks before start, full table, long output stalls and sender pauses");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
